@@ src/tfps_pkg.sv @@
// shared constants, types and helpers for the tlb / page map block
package tfps_pkg;

    localparam int TLB_ENTRIES = 128;
    localparam int PAGE_COUNT  = 1024;
    localparam int PAGE_BYTES  = 64;

    localparam int ADDR_W      = 16;
    localparam int PAGE_OUT_W  = 10;
    localparam int CNT_W       = 32;
    localparam int OUTCOME_W   = 2;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);

    // memory access cost per outcome
    localparam logic [1:0] MEM_COST_TLB_HIT  = 2'd2;
    localparam logic [1:0] MEM_COST_PAGE_HIT = 2'd3;
    localparam logic [1:0] MEM_COST_FAULT    = 2'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_TLB_HIT  = 2'd0,
        OUT_PAGE_HIT = 2'd1,
        OUT_FAULT    = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_stall;
    } t_dp_sts;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] val,
                                                 input logic [1:0] amt);
        logic [CNT_W:0] sum;
        sum = {1'b0, val} + {{(CNT_W-1){1'b0}}, amt};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

@@ src/tfps_if.sv @@
// request and result channel interfaces
interface tfps_in_if;
    logic                          valid;
    logic                          ready;
    logic [tfps_pkg::ADDR_W-1:0]   byte_address;

    modport source (output valid, output byte_address, input ready);
    modport sink   (input valid, input byte_address, output ready);
endinterface

interface tfps_out_if;
    logic                            valid;
    logic                            ready;
    logic [tfps_pkg::OUTCOME_W-1:0]  outcome;
    logic [tfps_pkg::PAGE_OUT_W-1:0] page_number;
    logic [tfps_pkg::CNT_W-1:0]      tlb_hit_count;
    logic [tfps_pkg::CNT_W-1:0]      tlb_miss_count;
    logic [tfps_pkg::CNT_W-1:0]      page_hit_count;
    logic [tfps_pkg::CNT_W-1:0]      page_fault_count;
    logic [tfps_pkg::CNT_W-1:0]      io_op_count;
    logic [tfps_pkg::CNT_W-1:0]      memory_access_count;

    modport source (output valid, output outcome, output page_number,
                    output tlb_hit_count, output tlb_miss_count,
                    output page_hit_count, output page_fault_count,
                    output io_op_count, output memory_access_count,
                    input ready);
    modport sink   (input valid, input outcome, input page_number,
                    input tlb_hit_count, input tlb_miss_count,
                    input page_hit_count, input page_fault_count,
                    input io_op_count, input memory_access_count,
                    output ready);
endinterface

@@ src/tlb_fifo_page_table_sim_top.sv @@
// top level of the tlb with fifo replacement in front of a page-present map
//
// request channel i_req carries one byte address; its page number is the
// address divided by the page size. the page is compared against every valid
// tlb entry in parallel; on a miss the page-present map is consulted, and on
// a fault the page is marked present and written into the fifo-oldest entry.
// result channel o_rsp returns one result per request: outcome, page number
// and six saturating running counts, taken after this request was counted.
// timing: a request is taken in the idle state; the map read and the result
// commit follow in the eval state, which is set by the registered read of the
// page map ram, and the commit waits there while the result register is held;
// o_rsp.valid rises at the commit edge, so the result can be taken from then on.
// reset: i_rst_n is synchronous; afterwards the page map is swept to zero one
// bit per cycle with i_req.ready low, then requests are taken.
// stall: the result register holds while o_rsp.ready is low; a new request
// may still be taken, and its commit waits until the result register frees.
module tlb_fifo_page_table_sim_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfps_in_if.sink     i_req,
    tfps_out_if.source  o_rsp
);

    // command and status between controller and datapath
    tfps_pkg::t_dp_cmd cmd;
    tfps_pkg::t_dp_sts sts;

    // controller sequences clear sweep, capture and commit
    tfps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    // datapath holds tlb, page map, counters and the result register
    tfps_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_byte_address        (i_req.byte_address),
        .i_out_ready           (o_rsp.ready),
        .o_sts                 (sts),
        .o_out_valid           (o_rsp.valid),
        .o_outcome             (o_rsp.outcome),
        .o_page_number         (o_rsp.page_number),
        .o_tlb_hit_count       (o_rsp.tlb_hit_count),
        .o_tlb_miss_count      (o_rsp.tlb_miss_count),
        .o_page_hit_count      (o_rsp.page_hit_count),
        .o_page_fault_count    (o_rsp.page_fault_count),
        .o_io_op_count         (o_rsp.io_op_count),
        .o_memory_access_count (o_rsp.memory_access_count)
    );

endmodule

@@ src/tfps_ram.sv @@
// generic single write port ram with registered read
module tfps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tfps_ctrl.sv @@
// controller: map clear sweep, request capture and result commit
module tfps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tfps_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output tfps_pkg::t_dp_cmd o_cmd
);

    tfps_pkg::t_state r_state;
    tfps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfps_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfps_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) n_state = tfps_pkg::ST_IDLE;
            end
            tfps_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tfps_pkg::ST_EVAL;
            end
            tfps_pkg::ST_EVAL: begin
                if (!i_sts.out_stall) n_state = tfps_pkg::ST_IDLE;
            end
            default: n_state = tfps_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.clear   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            tfps_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            tfps_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            tfps_pkg::ST_EVAL: begin
                o_cmd.commit = !i_sts.out_stall;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/tfps_dp.sv @@
// datapath: tlb tags, page map, fifo pointer, counters and result register
module tfps_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tfps_pkg::t_dp_cmd                 i_cmd,
    input  logic [tfps_pkg::ADDR_W-1:0]       i_byte_address,
    input  logic                              i_out_ready,
    output tfps_pkg::t_dp_sts                 o_sts,
    output logic                              o_out_valid,
    output logic [tfps_pkg::OUTCOME_W-1:0]    o_outcome,
    output logic [tfps_pkg::PAGE_OUT_W-1:0]   o_page_number,
    output logic [tfps_pkg::CNT_W-1:0]        o_tlb_hit_count,
    output logic [tfps_pkg::CNT_W-1:0]        o_tlb_miss_count,
    output logic [tfps_pkg::CNT_W-1:0]        o_page_hit_count,
    output logic [tfps_pkg::CNT_W-1:0]        o_page_fault_count,
    output logic [tfps_pkg::CNT_W-1:0]        o_io_op_count,
    output logic [tfps_pkg::CNT_W-1:0]        o_memory_access_count
);

    localparam int PW = tfps_pkg::PAGE_W;
    localparam int IW = tfps_pkg::TLB_IDX_W;
    localparam int CW = tfps_pkg::CNT_W;

    logic [PW-1:0]               r_tlb_tag [tfps_pkg::TLB_ENTRIES];
    logic [tfps_pkg::TLB_ENTRIES-1:0] r_tlb_valid;
    logic [IW-1:0]               r_repl_ptr;
    logic [PW-1:0]               r_clr_addr;
    logic [PW-1:0]               r_page;
    logic                        r_tlb_hit;
    logic                        r_out_valid;
    tfps_pkg::t_outcome          r_outcome;
    logic [PW-1:0]               r_out_page;
    logic [CW-1:0]               r_cnt_tlb_hit;
    logic [CW-1:0]               r_cnt_tlb_miss;
    logic [CW-1:0]               r_cnt_page_hit;
    logic [CW-1:0]               r_cnt_fault;
    logic [CW-1:0]               r_cnt_io;
    logic [CW-1:0]               r_cnt_mem;

    logic [tfps_pkg::ADDR_W-1:0] page_shifted;
    logic [PW-1:0]               page_in;
    logic                        tlb_hit;
    logic                        present;
    logic                        fault;
    tfps_pkg::t_outcome          outcome;
    logic                        ram_we;
    logic [PW-1:0]               ram_waddr;
    logic                        ram_wdata;
    logic [PW-1:0]               ram_raddr;

    // page number, reduced to the map size
    assign page_shifted = i_byte_address >> tfps_pkg::PAGE_SHIFT;
    assign page_in      = page_shifted[PW-1:0];

    // fully associative compare over all entries
    always_comb begin
        tlb_hit = 1'b0;
        for (int e = 0; e < tfps_pkg::TLB_ENTRIES; e++) begin
            if (r_tlb_valid[e] && (r_tlb_tag[e] == page_in)) tlb_hit = 1'b1;
        end
    end

    // page map: clear sweep writes zeros, a fault sets the bit
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_page;
        ram_wdata = 1'b1;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else if (i_cmd.commit && fault) begin
            ram_we = 1'b1;
        end
    end

    // read the incoming page at capture, then keep reading the held page
    assign ram_raddr = i_cmd.capture ? page_in : r_page;

    tfps_ram #(
        .WIDTH (1),
        .DEPTH (tfps_pkg::PAGE_COUNT)
    ) u_page_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (present)
    );

    assign fault = !r_tlb_hit && !present;

    always_comb begin
        if (r_tlb_hit)    outcome = tfps_pkg::OUT_TLB_HIT;
        else if (present) outcome = tfps_pkg::OUT_PAGE_HIT;
        else              outcome = tfps_pkg::OUT_FAULT;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid    <= '0;
            r_repl_ptr     <= '0;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
            r_cnt_tlb_hit  <= '0;
            r_cnt_tlb_miss <= '0;
            r_cnt_page_hit <= '0;
            r_cnt_fault    <= '0;
            r_cnt_io       <= '0;
            r_cnt_mem      <= '0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (r_tlb_hit) begin
                    r_cnt_tlb_hit <= tfps_pkg::sat_add(r_cnt_tlb_hit, 2'd1);
                    r_cnt_mem     <= tfps_pkg::sat_add(r_cnt_mem, tfps_pkg::MEM_COST_TLB_HIT);
                end else begin
                    r_cnt_tlb_miss <= tfps_pkg::sat_add(r_cnt_tlb_miss, 2'd1);
                    if (present) begin
                        r_cnt_page_hit <= tfps_pkg::sat_add(r_cnt_page_hit, 2'd1);
                        r_cnt_mem <= tfps_pkg::sat_add(r_cnt_mem, tfps_pkg::MEM_COST_PAGE_HIT);
                    end else begin
                        r_cnt_fault <= tfps_pkg::sat_add(r_cnt_fault, 2'd1);
                        r_cnt_io    <= tfps_pkg::sat_add(r_cnt_io, 2'd1);
                        r_cnt_mem   <= tfps_pkg::sat_add(r_cnt_mem, tfps_pkg::MEM_COST_FAULT);
                        r_tlb_valid[r_repl_ptr] <= 1'b1;
                        if (r_repl_ptr == IW'(tfps_pkg::TLB_ENTRIES - 1)) begin
                            r_repl_ptr <= '0;
                        end else begin
                            r_repl_ptr <= r_repl_ptr + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page    <= page_in;
            r_tlb_hit <= tlb_hit;
        end
        if (i_cmd.commit) begin
            r_outcome  <= outcome;
            r_out_page <= r_page;
            if (fault) r_tlb_tag[r_repl_ptr] <= r_page;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == PW'(tfps_pkg::PAGE_COUNT - 1));
    assign o_sts.out_stall  = r_out_valid && !i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_outcome             = r_outcome;
    assign o_page_number         = tfps_pkg::PAGE_OUT_W'(r_out_page);
    assign o_tlb_hit_count       = r_cnt_tlb_hit;
    assign o_tlb_miss_count      = r_cnt_tlb_miss;
    assign o_page_hit_count      = r_cnt_page_hit;
    assign o_page_fault_count    = r_cnt_fault;
    assign o_io_op_count         = r_cnt_io;
    assign o_memory_access_count = r_cnt_mem;

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result not presented after commit");

    a_ptr_moves_on_fault_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && fault) |=> $stable(r_repl_ptr))
        else $error("replace pointer moved without a fault");

    a_counts_move_on_commit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> ($stable(r_cnt_mem) && $stable(r_cnt_tlb_miss)))
        else $error("counter changed without a commit");

    a_no_commit_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.commit)
        else $error("result overwritten while receiver stalls");

endmodule

@@ verif/tfps_tb_pkg.sv @@
// scoreboard class that predicts tlb and page map lookups and checks each result
package tfps_tb_pkg;

    import tfps_pkg::*;

    typedef struct packed {
        t_outcome                outcome;
        logic [PAGE_OUT_W-1:0]   page_number;
        logic [CNT_W-1:0]        tlb_hits;
        logic [CNT_W-1:0]        tlb_misses;
        logic [CNT_W-1:0]        page_hits;
        logic [CNT_W-1:0]        page_faults;
        logic [CNT_W-1:0]        io_ops;
        logic [CNT_W-1:0]        mem_accesses;
    } lookup_result_t;

    class lookup_scoreboard;

        logic [PAGE_W-1:0]     tag_mem [TLB_ENTRIES];
        bit                    entry_valid [TLB_ENTRIES];
        bit                    page_mapped [PAGE_COUNT];
        logic [TLB_IDX_W-1:0]  victim_ptr;
        logic [CNT_W-1:0]      tlb_hits;
        logic [CNT_W-1:0]      tlb_misses;
        logic [CNT_W-1:0]      page_hits;
        logic [CNT_W-1:0]      page_faults;
        logic [CNT_W-1:0]      io_ops;
        logic [CNT_W-1:0]      mem_accesses;
        lookup_result_t        expected_lookups [$];
        int unsigned           mismatches;

        function new();
            foreach (tag_mem[i]) begin
                tag_mem[i]     = '0;
                entry_valid[i] = 1'b0;
            end
            foreach (page_mapped[i]) page_mapped[i] = 1'b0;
            victim_ptr   = '0;
            tlb_hits     = '0;
            tlb_misses   = '0;
            page_hits    = '0;
            page_faults  = '0;
            io_ops       = '0;
            mem_accesses = '0;
            mismatches   = 0;
        endfunction

        // counters stick at all ones
        function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] cur, int unsigned amount);
            logic [CNT_W:0] wide;
            wide = {1'b0, cur} + (CNT_W+1)'(amount);
            return wide[CNT_W] ? {CNT_W{1'b1}} : wide[CNT_W-1:0];
        endfunction

        function void note_request(logic [ADDR_W-1:0] addr);
            lookup_result_t   want;
            logic [PAGE_W-1:0] page;
            bit               in_tlb;
            page   = PAGE_W'((addr / PAGE_BYTES) % PAGE_COUNT);
            in_tlb = 1'b0;
            for (int e = 0; e < TLB_ENTRIES; e++) begin
                if (entry_valid[e] && tag_mem[e] == page) in_tlb = 1'b1;
            end
            if (in_tlb) begin
                want.outcome = OUT_TLB_HIT;
                tlb_hits     = count_up(tlb_hits, 1);
                mem_accesses = count_up(mem_accesses, 2);
            end else begin
                tlb_misses = count_up(tlb_misses, 1);
                if (page_mapped[page]) begin
                    // present in the map, tlb left alone
                    want.outcome = OUT_PAGE_HIT;
                    page_hits    = count_up(page_hits, 1);
                    mem_accesses = count_up(mem_accesses, 3);
                end else begin
                    want.outcome          = OUT_FAULT;
                    page_faults           = count_up(page_faults, 1);
                    io_ops                = count_up(io_ops, 1);
                    mem_accesses          = count_up(mem_accesses, 2);
                    page_mapped[page]     = 1'b1;
                    tag_mem[victim_ptr]   = page;
                    entry_valid[victim_ptr] = 1'b1;
                    victim_ptr            = victim_ptr + 1'b1;
                end
            end
            want.page_number  = PAGE_OUT_W'(page);
            want.tlb_hits     = tlb_hits;
            want.tlb_misses   = tlb_misses;
            want.page_hits    = page_hits;
            want.page_faults  = page_faults;
            want.io_ops       = io_ops;
            want.mem_accesses = mem_accesses;
            expected_lookups.push_back(want);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual page %0d outcome %0d",
                         $time, got.page_number, got.outcome);
                mismatches++;
                return;
            end
            want = expected_lookups.pop_front();
            compare_field("outcome", want.outcome, got.outcome);
            compare_field("page_number", want.page_number, got.page_number);
            compare_field("tlb_hit_count", want.tlb_hits, got.tlb_hits);
            compare_field("tlb_miss_count", want.tlb_misses, got.tlb_misses);
            compare_field("page_hit_count", want.page_hits, got.page_hits);
            compare_field("page_fault_count", want.page_faults, got.page_faults);
            compare_field("io_op_count", want.io_ops, got.io_ops);
            compare_field("memory_access_count", want.mem_accesses, got.mem_accesses);
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

    endclass

endpackage

@@ verif/tlb_fifo_page_table_sim_top_tb.sv @@
// testbench for the fifo-replacement tlb in front of the page-present map
module tlb_fifo_page_table_sim_top_tb;

    import tfps_pkg::*;
    import tfps_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfps_in_if  req_if ();
    tfps_out_if rsp_if ();

    tlb_fifo_page_table_sim_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // edge addresses: first and last byte of the lowest, highest and middle pages,
    // alternating bit patterns, and repeats that must hit in the tlb
    localparam int EDGE_COUNT = 12;
    localparam logic [ADDR_W-1:0] EDGE_ADDRS [EDGE_COUNT] = '{
        16'h0000, 16'h003F, 16'hFFFF, 16'hFFC0, 16'h0040, 16'h007F,
        16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h5540, 16'hFFFF
    };

    lookup_scoreboard  sb;

    // idle and stall odds in percent, changed per phase
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    // long receiver hold-off: the stimulus posts a length, the receiver counts it down
    int unsigned       hold_request   = 0;
    int unsigned       hold_left      = 0;

    // pages already touched, used to steer random addresses toward hits
    bit                page_seen [PAGE_COUNT];
    logic [PAGE_W-1:0] seen_pages [$];
    logic [PAGE_W-1:0] recent_pages [$];
    logic [PAGE_W-1:0] sweep_pages [$];

    always #5 i_clk = ~i_clk;

    // result side ready, driven at the falling edge
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sample both channels at the rising edge; results are checked before the
    // request of the same edge is noted, the block cannot answer that fast anyway
    always @(posedge i_clk) begin
        lookup_result_t got;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.outcome      = t_outcome'(rsp_if.outcome);
            got.page_number  = rsp_if.page_number;
            got.tlb_hits     = rsp_if.tlb_hit_count;
            got.tlb_misses   = rsp_if.tlb_miss_count;
            got.page_hits    = rsp_if.page_hit_count;
            got.page_faults  = rsp_if.page_fault_count;
            got.io_ops       = rsp_if.io_op_count;
            got.mem_accesses = rsp_if.memory_access_count;
            sb.check_result(got);
        end
        if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            sb.note_request(req_if.byte_address);
        end
    end

    // offer one request, with random idle cycles ahead of it; returns at a falling edge
    task automatic push_address(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0] page;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.byte_address <= addr;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        page = addr[ADDR_W-1:PAGE_SHIFT];
        if (!page_seen[page]) begin
            page_seen[page] = 1'b1;
            seen_pages.push_back(page);
        end
        recent_pages.push_back(page);
        if (recent_pages.size() > 16) void'(recent_pages.pop_front());
    endtask

    // mostly revisits (tlb hits and, after eviction, page hits), rest fresh addresses
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned       r;
        logic [PAGE_W-1:0] page;
        r = $urandom_range(99);
        if (r < 35 && recent_pages.size() > 0) begin
            page = recent_pages[$urandom_range(recent_pages.size() - 1)];
        end else if (r < 65 && seen_pages.size() > 0) begin
            page = seen_pages[$urandom_range(seen_pages.size() - 1)];
        end else begin
            return ADDR_W'($urandom);
        end
        return {page, PAGE_SHIFT'($urandom)};
    endfunction

    // stop offering until every outstanding result has been returned
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) push_address(pick_address());
    endtask

    initial begin
        logic [PAGE_W-1:0] page;
        sb                  = new();
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.byte_address = '0;
        rsp_if.ready        = 1'b0;
        foreach (page_seen[i]) page_seen[i] = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the map clear pass after reset shows as ready low; push_address waits it out

        // directed: field extremes, faults, tlb hits on the same page
        foreach (EDGE_ADDRS[i]) push_address(EDGE_ADDRS[i]);
        wait_drained();

        // fill the tlb past its size with fresh pages so the fifo wraps and evicts
        repeat (132) begin
            do page = PAGE_W'($urandom_range(PAGE_COUNT - 1)); while (page_seen[page]);
            sweep_pages.push_back(page);
            push_address({page, PAGE_SHIFT'($urandom)});
        end
        // the edge pages were evicted: these are page hits with no refill
        foreach (EDGE_ADDRS[i]) push_address(EDGE_ADDRS[i]);
        // newest sweep pages still sit in the tlb
        for (int i = 126; i < 132; i++) push_address({sweep_pages[i], PAGE_SHIFT'($urandom)});
        wait_drained();

        // no idling, with one long result hold-off so the block backs up into its input
        run_phase(0, 0, 60);
        hold_request = 400;
        run_phase(0, 0, 380);
        wait_drained();

        run_phase(84, 0, 440);
        wait_drained();
        run_phase(0, 84, 440);
        wait_drained();
        run_phase(37, 37, 440);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tfps_pkg.sv
src/tfps_if.sv
src/tfps_ram.sv
src/tfps_ctrl.sv
src/tfps_dp.sv
src/tlb_fifo_page_table_sim_top.sv
verif/tfps_tb_pkg.sv
verif/tlb_fifo_page_table_sim_top_tb.sv
